/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL. Simulation builds get the checks,
// synthesis builds get empty macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* sv/mbsp_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI byte stream parser package
// Types and constants shared by the parser decode logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mbsp_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned DataW = 7;
    localparam int unsigned KindW = 2;

    localparam logic [KindW-1:0] KIND_MESSAGE  = 2'd0;
    localparam logic [KindW-1:0] KIND_SYSEX    = 2'd1;
    localparam logic [KindW-1:0] KIND_REALTIME = 2'd2;

    localparam logic [ByteW-1:0] STATUS_SYSEX     = 8'hF0;
    localparam logic [ByteW-1:0] STATUS_MTC_QF    = 8'hF1;
    localparam logic [ByteW-1:0] STATUS_SONG_SEL  = 8'hF3;
    localparam logic [3:0]       NIBBLE_PROG_CHG  = 4'hC;
    localparam logic [3:0]       NIBBLE_CHAN_PRES = 4'hD;
    localparam logic [3:0]       NIBBLE_SYSTEM    = 4'hF;
    // Real-time bytes are 0xF8 through 0xFF: the top five bits are all set.
    localparam logic [4:0]       REALTIME_PREFIX  = 5'b11111;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ONE    = 2'd1,
        PH_FIRST  = 2'd2,
        PH_SECOND = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase           phase;
        logic [ByteW-1:0] run_status;
        logic [DataW-1:0] held_data;
    } t_parse_state;

    typedef struct packed {
        logic             valid;
        logic [KindW-1:0] kind;
        logic [ByteW-1:0] status;
        logic [DataW-1:0] data1;
        logic [DataW-1:0] data2;
    } t_result;

endpackage

`default_nettype wire

/* sv/mbsp_decode.sv */
// ----------------------------------------------------------------------------
// MIDI parser byte decode
// Combinational next-state and result logic for one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mbsp_decode (
    input  wire logic [mbsp_pkg::ByteW-1:0] i_byte,
    input  wire mbsp_pkg::t_parse_state     i_state,
    output mbsp_pkg::t_parse_state          o_state,
    output mbsp_pkg::t_result               o_result
);
    import mbsp_pkg::*;

    logic             is_realtime;
    logic             one_data;
    logic             have_status;
    logic             status_common;
    logic [DataW-1:0] data_bits;

    assign is_realtime   = (i_byte[ByteW-1:ByteW-5] == REALTIME_PREFIX);
    assign one_data      = (i_byte[ByteW-1:ByteW-4] == NIBBLE_PROG_CHG)
                        || (i_byte[ByteW-1:ByteW-4] == NIBBLE_CHAN_PRES)
                        || (i_byte == STATUS_MTC_QF)
                        || (i_byte == STATUS_SONG_SEL);
    assign have_status   = (i_state.run_status != '0);
    assign status_common = (i_state.run_status[ByteW-1:ByteW-4] == NIBBLE_SYSTEM);
    assign data_bits     = i_byte[DataW-1:0];

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (is_realtime) begin
            o_result.valid  = 1'b1;
            o_result.kind   = KIND_REALTIME;
            o_result.status = i_byte;
        end else if (i_byte[ByteW-1]) begin
            o_state.run_status = i_byte;
            if (i_byte == STATUS_SYSEX) begin
                o_state.phase   = PH_IDLE;
                o_result.valid  = 1'b1;
                o_result.kind   = KIND_SYSEX;
                o_result.status = STATUS_SYSEX;
            end else if (one_data) begin
                o_state.phase = PH_ONE;
            end else begin
                o_state.phase = PH_FIRST;
            end
        end else begin
            unique case (i_state.phase)
                PH_ONE: begin
                    o_result.valid  = have_status;
                    o_result.kind   = KIND_MESSAGE;
                    o_result.status = i_state.run_status;
                    o_result.data1  = data_bits;
                    if (status_common) begin
                        o_state.run_status = '0;
                    end
                end
                PH_FIRST: begin
                    o_state.held_data = data_bits;
                    o_state.phase     = PH_SECOND;
                end
                PH_SECOND: begin
                    o_state.phase   = PH_FIRST;
                    o_result.valid  = have_status;
                    o_result.kind   = KIND_MESSAGE;
                    o_result.status = i_state.run_status;
                    o_result.data1  = i_state.held_data;
                    o_result.data2  = data_bits;
                    if (status_common) begin
                        o_state.run_status = '0;
                    end
                end
                default: begin
                    // Data while idle or inside sysex is dropped.
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/midi_byte_stream_parser.sv */
// ----------------------------------------------------------------------------
// MIDI byte stream parser
// Rebuilds MIDI messages with running status from a stream of received bytes.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one received byte per request on i_rx_byte, with
// i_valid from the sender and o_stall back to it. The output channel gives
// one parsed message per request on o_msg_* with o_valid, and the receiver
// holds it with i_stall. A byte is held in the input register and then
// parsed into the result register, which drives o_valid; a held output
// can keep the byte waiting in the input register.
// One byte is taken in every cycle while the output is not held, so the
// sustained rate is one byte per cycle; the parse state update in the second
// stage is a single step and sets that figure. Bytes that complete no
// message simply leave an empty slot. Real-time bytes take the same path and
// are never held back by a partial message.
// While i_stall holds a waiting result, the input register still takes one
// more byte, then o_stall rises until the result is taken.
// Reset (i_rst_n low, synchronous) empties both registers, returns the parser
// to idle and clears the running status and held data byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module midi_byte_stream_parser (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [mbsp_pkg::ByteW-1:0]   i_rx_byte,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic      [mbsp_pkg::KindW-1:0]   o_msg_kind,
    output logic      [mbsp_pkg::ByteW-1:0]   o_msg_status,
    output logic      [mbsp_pkg::DataW-1:0]   o_msg_data1,
    output logic      [mbsp_pkg::DataW-1:0]   o_msg_data2
);
    import mbsp_pkg::*;

    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    t_parse_state     r_state;
    t_parse_state     n_state;
    t_result          r_out;
    t_result          n_out;
    logic             out_ready;
    logic             in_take;
    logic             stage_fire;

    // The result register can load when it is empty or being drained.
    assign out_ready  = !r_out.valid || !i_stall;
    assign stage_fire = r_in_valid && out_ready;
    assign o_stall    = r_in_valid && !out_ready;
    assign in_take    = i_valid && !o_stall;

    mbsp_decode u_decode (
        .i_byte   (r_in_byte),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (stage_fire) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{phase: PH_IDLE, run_status: '0, held_data: '0};
            r_out.valid <= 1'b0;
        end else begin
            if (stage_fire) begin
                r_state     <= n_state;
                r_out.valid <= n_out.valid;
            end else if (out_ready) begin
                r_out.valid <= 1'b0;
            end
        end
        if (stage_fire) begin
            r_out.kind   <= n_out.kind;
            r_out.status <= n_out.status;
            r_out.data1  <= n_out.data1;
            r_out.data2  <= n_out.data2;
        end
    end

    assign o_valid      = r_out.valid;
    assign o_msg_kind   = r_out.kind;
    assign o_msg_status = r_out.status;
    assign o_msg_data1  = r_out.data1;
    assign o_msg_data2  = r_out.data2;

    // A channel status never leaves the parser idle; only sysex start does.
    `ASSERT_CLK(a_status_phase, i_clk, i_rst_n,
        (r_state.run_status != '0 && r_state.run_status != STATUS_SYSEX)
            |-> (r_state.phase != PH_IDLE))
    `ASSERT_CLK(a_realtime_clean, i_clk, i_rst_n,
        (r_out.valid && r_out.kind == KIND_REALTIME)
            |-> (r_out.status[ByteW-1:ByteW-5] == REALTIME_PREFIX
                 && r_out.data1 == '0 && r_out.data2 == '0))
    `ASSERT_CLK(a_sysex_status, i_clk, i_rst_n,
        (r_out.valid && r_out.kind == KIND_SYSEX) |-> (r_out.status == STATUS_SYSEX))
    `ASSERT_NEVER(a_stall_empty, i_clk, i_rst_n, o_stall && !r_in_valid)

endmodule

`default_nettype wire

/* test/midi_byte_stream_parser_tb.sv */
// ----------------------------------------------------------------------------
// MIDI byte stream parser testbench
// Feeds directed and random MIDI byte streams through the parser with random
// gaps and back-pressure, predicts every message it should rebuild, and checks
// each result field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_byte_stream_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbsp_pkg::*;

    localparam int unsigned CycleLimit = 100000;
    localparam int unsigned RandomBytes = 500;
    localparam int unsigned IdlePct = 31;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [ByteW-1:0] status;
        logic [DataW-1:0] data1;
        logic [DataW-1:0] data2;
    } t_midi_msg;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [ByteW-1:0]   i_rx_byte = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [KindW-1:0]   o_msg_kind;
    logic [ByteW-1:0]   o_msg_status;
    logic [DataW-1:0]   o_msg_data1;
    logic [DataW-1:0]   o_msg_data2;

    midi_byte_stream_parser u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_msg_kind   (o_msg_kind),
        .o_msg_status (o_msg_status),
        .o_msg_data1  (o_msg_data1),
        .o_msg_data2  (o_msg_data2)
    );

    always #5 i_clk = ~i_clk;

    logic [ByteW-1:0] rx_bytes_q[$];
    t_midi_msg        expected_msgs[$];

    // Predicted parser state.
    t_phase           ps_phase = PH_IDLE;
    logic [ByteW-1:0] ps_run_status = '0;
    logic [DataW-1:0] ps_held = '0;

    int unsigned bytes_sent = 0;
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned n_message = 0;
    int unsigned n_sysex = 0;
    int unsigned n_realtime = 0;
    logic        no_gaps;

    // A burst of requests in the middle of the run sees no gaps on either side.
    assign no_gaps = (bytes_sent >= 200) && (bytes_sent < 320);

    // Emits the finished message if a status is held; system common clears it.
    function automatic bit complete_msg(input logic [DataW-1:0] d1,
                                        input logic [DataW-1:0] d2,
                                        output t_midi_msg m);
        m = '0;
        if (ps_run_status == '0) return 1'b0;
        m.kind = KIND_MESSAGE;
        m.status = ps_run_status;
        m.data1 = d1;
        m.data2 = d2;
        if (ps_run_status[7:4] == NIBBLE_SYSTEM) ps_run_status = '0;
        return 1'b1;
    endfunction

    // Advances the predicted state by one byte; returns 1 if a result is due.
    function automatic bit parse_midi_byte(input logic [ByteW-1:0] b,
                                           output t_midi_msg m);
        bit got;
        m = '0;
        got = 1'b0;
        if (b[7:3] == REALTIME_PREFIX) begin
            m.kind = KIND_REALTIME;
            m.status = b;
            got = 1'b1;
        end else if (b[7]) begin
            ps_run_status = b;
            if (b == STATUS_SYSEX) begin
                ps_phase = PH_IDLE;
                m.kind = KIND_SYSEX;
                m.status = STATUS_SYSEX;
                got = 1'b1;
            end else if (b[7:4] == NIBBLE_PROG_CHG || b[7:4] == NIBBLE_CHAN_PRES ||
                         b == STATUS_MTC_QF || b == STATUS_SONG_SEL) begin
                ps_phase = PH_ONE;
            end else begin
                ps_phase = PH_FIRST;
            end
        end else begin
            case (ps_phase)
                PH_ONE: begin
                    got = complete_msg(b[DataW-1:0], '0, m);
                end
                PH_FIRST: begin
                    ps_held = b[DataW-1:0];
                    ps_phase = PH_SECOND;
                end
                PH_SECOND: begin
                    ps_phase = PH_FIRST;
                    got = complete_msg(ps_held, b[DataW-1:0], m);
                end
                default: ;
            endcase
        end
        return got;
    endfunction

    function automatic int unsigned data_len(input logic [ByteW-1:0] s);
        if (s == STATUS_SYSEX) return 0;
        if (s[7:4] == NIBBLE_PROG_CHG || s[7:4] == NIBBLE_CHAN_PRES ||
            s == STATUS_MTC_QF || s == STATUS_SONG_SEL) return 1;
        return 2;
    endfunction

    // Queues one byte, now and then with a real-time byte slipped in ahead.
    task automatic add_byte(input logic [ByteW-1:0] b);
        logic [2:0] rt;
        rt = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 6) rx_bytes_q.push_back({REALTIME_PREFIX, rt});
        rx_bytes_q.push_back(b);
    endtask

    task automatic add_data_bytes(input int unsigned count);
        logic [DataW-1:0] d;
        for (int unsigned i = 0; i < count; i++) begin
            d = 7'($urandom_range(0, 127));
            add_byte({1'b0, d});
        end
    endtask

    // Driver: presents queued bytes and predicts each accepted request.
    always @(posedge i_clk) begin
        t_midi_msg m;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                bytes_sent <= bytes_sent + 1;
                if (parse_midi_byte(i_rx_byte, m)) expected_msgs.push_back(m);
            end
            if (!i_valid || !o_stall) begin
                if (rx_bytes_q.size() != 0 &&
                    (no_gaps || $urandom_range(0, 99) >= IdlePct)) begin
                    i_valid <= 1'b1;
                    i_rx_byte <= rx_bytes_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and in-order check of every result.
    always @(posedge i_clk) begin
        t_midi_msg exp_msg;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_msgs.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("ERROR: unexpected result kind=%0d status=%h d1=%h d2=%h",
                                 o_msg_kind, o_msg_status, o_msg_data1, o_msg_data2);
                end else begin
                    exp_msg = expected_msgs.pop_front();
                    if (o_msg_kind !== exp_msg.kind || o_msg_status !== exp_msg.status ||
                        o_msg_data1 !== exp_msg.data1 || o_msg_data2 !== exp_msg.data2) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("ERROR: expected kind=%0d status=%h d1=%h d2=%h,",
                                     exp_msg.kind, exp_msg.status, exp_msg.data1,
                                     exp_msg.data2,
                                     " got kind=%0d status=%h d1=%h d2=%h",
                                     o_msg_kind, o_msg_status,
                                     o_msg_data1, o_msg_data2);
                    end
                    case (exp_msg.kind)
                        KIND_MESSAGE:  n_message <= n_message + 1;
                        KIND_SYSEX:    n_sysex <= n_sysex + 1;
                        default:       n_realtime <= n_realtime + 1;
                    endcase
                end
            end
            i_stall <= no_gaps ? 1'b0 : ($urandom_range(0, 99) < IdlePct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [ByteW-1:0] directed[] = '{
            8'h00,                          // data with no status
            8'h90, 8'h3C, 8'h7F,            // note on
            8'h40, 8'hF8, 8'h00,            // running status, real-time inside
            8'hC5, 8'h7F, 8'h01,            // program change and running status
            8'hE0, 8'h55, 8'hB0, 8'h07, 8'h64, // new status drops the partial one
            8'hF0, 8'h12,                   // sysex start, its data ignored
            8'hF7, 8'h01, 8'h02, 8'h03, 8'h04, // system common, then ignored data
            8'hF1, 8'h00, 8'hFF,
            8'hF3, 8'h7F
        };
        logic [ByteW-1:0] st;
        int unsigned sel;
        int unsigned runs;
        int unsigned len;
        bit cut;

        foreach (directed[i]) rx_bytes_q.push_back(directed[i]);

        // Mostly well-formed messages with running status, some cut short,
        // plus system common, sysex and plain noise.
        while (rx_bytes_q.size() < directed.size() + RandomBytes) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                st[7:4] = 4'($urandom_range(8, 14));
                st[3:0] = 4'($urandom_range(0, 15));
                len = data_len(st);
                runs = $urandom_range(1, 4);
                cut = ($urandom_range(0, 99) < 8);
                add_byte(st);
                for (int unsigned r = 0; r < runs; r++)
                    for (int unsigned k = 0; k < len; k++)
                        if (!(cut && r == runs - 1 && k == len - 1))
                            add_data_bytes(1);
            end else if (sel < 80) begin
                st = STATUS_MTC_QF + 8'($urandom_range(0, 6));
                add_byte(st);
                add_data_bytes(data_len(st) + $urandom_range(0, 2));
            end else if (sel < 86) begin
                add_byte(STATUS_SYSEX);
                add_data_bytes($urandom_range(0, 5));
            end else begin
                st = 8'($urandom_range(0, 255));
                add_byte(st);
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_bytes_q.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_msgs.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (expected_msgs.size() != 0) fail_count++;
        $display("Sent %0d bytes over %0d cycles with random gaps and back-pressure.",
                 bytes_sent, cycle_count);
        $display("Checked %0d messages, %0d sysex starts, %0d real-time bytes; %0d failures.",
                 n_message, n_sysex, n_realtime, fail_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
